>>> hdl/lpbr_pkg.sv
// ----------------------------------------------------------------------------
// lpbr_pkg
// Shared types and codes for the length-prefixed byte ring.
// ----------------------------------------------------------------------------
package lpbr_pkg;

   // Default geometry
   localparam int RING_BYTES_DEF = 4096;
   localparam int LEN_BYTES_DEF  = 4;

   // Field widths
   localparam int OP_W     = 2;
   localparam int LEN_W    = 12;
   localparam int BYTE_W   = 8;
   localparam int STAT_W   = 2;
   localparam int LIMIT_W  = 13;
   localparam int ADDR_MAX = 16;  // widest ring address supported
   localparam int SUM_W    = 18;  // occupancy and space arithmetic

   // Input opcodes
   localparam logic [OP_W-1:0] OP_INS_HDR  = 2'd0;
   localparam logic [OP_W-1:0] OP_INS_BYTE = 2'd1;
   localparam logic [OP_W-1:0] OP_FETCH    = 2'd2;
   localparam logic [OP_W-1:0] OP_READ     = 2'd3;

   // Result status codes
   localparam logic [STAT_W-1:0] ST_OK     = 2'd0;
   localparam logic [STAT_W-1:0] ST_REJECT = 2'd1;
   localparam logic [STAT_W-1:0] ST_EMPTY  = 2'd2;
   localparam logic [STAT_W-1:0] ST_SEQ    = 2'd3;

   // Back-end command kinds
   localparam logic [1:0] CMD_NONE = 2'd0;
   localparam logic [1:0] CMD_HDR  = 2'd1;
   localparam logic [1:0] CMD_WR   = 2'd2;
   localparam logic [1:0] CMD_RD   = 2'd3;

   localparam int CMDQ_DEPTH = 2;

   // One classified item, handed from front to back
   typedef struct packed {
      logic [1:0]          kind;
      logic [ADDR_MAX-1:0] addr;
      logic [15:0]         wdata;
      logic [STAT_W-1:0]   status;
      logic [LEN_W-1:0]    fetch_size;
      logic                last;
      logic                empty;
   } lpbr_cmd_type;

endpackage

>>> hdl/lpbr_front.sv
// ----------------------------------------------------------------------------
// lpbr_front
// Accepts items, checks sequencing and space, owns all ring pointers and
// issues one command with its precomputed result per item.
// ----------------------------------------------------------------------------
module lpbr_front #(
   parameter int RING_BYTES = lpbr_pkg::RING_BYTES_DEF,
   parameter int LEN_BYTES  = lpbr_pkg::LEN_BYTES_DEF
) (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          req_push,
   output logic                          req_full,
   input  logic [lpbr_pkg::OP_W-1:0]     req_opcode,
   input  logic [lpbr_pkg::LEN_W-1:0]    req_request_len,
   input  logic [lpbr_pkg::BYTE_W-1:0]   req_data_byte,
   input  logic                          csr_valid,
   output logic                          csr_ready,
   input  logic [lpbr_pkg::LIMIT_W-1:0]  csr_data,
   output logic                          cmd_valid,
   output lpbr_pkg::lpbr_cmd_type        cmd,
   input  logic                          cmd_ready
);

   localparam int AW = $clog2(RING_BYTES);
   localparam int SW = lpbr_pkg::SUM_W;

   logic [AW-1:0]                  head_ff, head_in;
   logic [AW-1:0]                  tail_ff, tail_in;
   logic [AW-1:0]                  wptr_ff, wptr_in;
   logic [AW-1:0]                  fend_ff, fend_in;
   logic [lpbr_pkg::LEN_W-1:0]     left_ff, left_in;
   logic                           ins_open_ff, ins_open_in;
   logic                           fet_open_ff, fet_open_in;
   logic [lpbr_pkg::LIMIT_W-1:0]   limit_ff, limit_in;

   logic          accept;
   logic [AW-1:0] occ;
   logic [SW-1:0] occ_x, total_x, room_x;
   logic          reject;

   assign req_full  = !cmd_ready;
   assign accept    = req_push && cmd_ready;
   assign cmd_valid = accept;
   assign csr_ready = 1'b1;

   // occupancy and space check
   assign occ     = tail_ff - head_ff;
   assign occ_x   = SW'(occ);
   assign total_x = SW'(LEN_BYTES) + SW'(req_request_len);
   assign room_x  = SW'(RING_BYTES) - occ_x;
   assign reject  = (occ_x >= SW'(limit_ff)) || (total_x >= room_x);

   // classify item, update pointers
   always_comb begin
      head_in     = head_ff;
      tail_in     = tail_ff;
      wptr_in     = wptr_ff;
      fend_in     = fend_ff;
      left_in     = left_ff;
      ins_open_in = ins_open_ff;
      fet_open_in = fet_open_ff;
      limit_in    = (csr_valid && csr_ready) ? csr_data : limit_ff;
      cmd         = '0;
      cmd.kind    = lpbr_pkg::CMD_NONE;
      cmd.status  = lpbr_pkg::ST_OK;
      case (req_opcode)
         lpbr_pkg::OP_INS_HDR: begin
            if (ins_open_ff) begin
               cmd.status = lpbr_pkg::ST_SEQ;
            end else if (reject) begin
               cmd.status = lpbr_pkg::ST_REJECT;
            end else begin
               cmd.kind  = lpbr_pkg::CMD_HDR;
               cmd.addr  = lpbr_pkg::ADDR_MAX'(tail_ff);
               cmd.wdata = 16'(total_x);
               wptr_in   = tail_ff + AW'(LEN_BYTES);
               left_in   = req_request_len;
               if (req_request_len == '0) begin
                  tail_in = tail_ff + AW'(LEN_BYTES);
               end else begin
                  ins_open_in = 1'b1;
               end
            end
         end
         lpbr_pkg::OP_INS_BYTE: begin
            if (!ins_open_ff) begin
               cmd.status = lpbr_pkg::ST_SEQ;
            end else begin
               cmd.kind  = lpbr_pkg::CMD_WR;
               cmd.addr  = lpbr_pkg::ADDR_MAX'(wptr_ff);
               cmd.wdata = 16'(req_data_byte);
               wptr_in   = wptr_ff + 1'b1;
               left_in   = left_ff - 1'b1;
               if (left_ff == 12'd1) begin
                  tail_in     = wptr_ff + 1'b1;
                  ins_open_in = 1'b0;
               end
            end
         end
         lpbr_pkg::OP_FETCH: begin
            if (fet_open_ff) begin
               cmd.status = lpbr_pkg::ST_SEQ;
            end else if (head_ff == tail_ff) begin
               cmd.status = lpbr_pkg::ST_EMPTY;
            end else begin
               fend_in         = tail_ff;
               fet_open_in     = 1'b1;
               cmd.fetch_size  = lpbr_pkg::LEN_W'(occ_x);
            end
         end
         default: begin
            if (!fet_open_ff) begin
               cmd.status = lpbr_pkg::ST_SEQ;
            end else begin
               cmd.kind = lpbr_pkg::CMD_RD;
               cmd.addr = lpbr_pkg::ADDR_MAX'(head_ff);
               head_in  = head_ff + 1'b1;
               if (head_ff + 1'b1 == fend_ff) begin
                  cmd.last    = 1'b1;
                  fet_open_in = 1'b0;
               end
            end
         end
      endcase
      cmd.empty = (head_in == tail_in);
   end

   // state registers
   always_ff @(posedge clock) begin
      if (reset) begin
         head_ff     <= '0;
         tail_ff     <= '0;
         wptr_ff     <= '0;
         fend_ff     <= '0;
         left_ff     <= '0;
         ins_open_ff <= 1'b0;
         fet_open_ff <= 1'b0;
         limit_ff    <= lpbr_pkg::LIMIT_W'(4096);
      end else begin
         limit_ff <= limit_in;
         if (accept) begin
            head_ff     <= head_in;
            tail_ff     <= tail_in;
            wptr_ff     <= wptr_in;
            fend_ff     <= fend_in;
            left_ff     <= left_in;
            ins_open_ff <= ins_open_in;
            fet_open_ff <= fet_open_in;
         end
      end
   end

endmodule

>>> hdl/lpbr_back.sv
// ----------------------------------------------------------------------------
// lpbr_back
// Command queue, single-port ring memory and result register. Executes
// header writes byte by byte, payload writes and byte reads in order.
// ----------------------------------------------------------------------------
module lpbr_back #(
   parameter int RING_BYTES = lpbr_pkg::RING_BYTES_DEF,
   parameter int LEN_BYTES  = lpbr_pkg::LEN_BYTES_DEF
) (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          cmd_valid,
   input  lpbr_pkg::lpbr_cmd_type        cmd,
   output logic                          cmd_ready,
   output logic                          rsp_empty,
   input  logic                          rsp_pop,
   output logic [lpbr_pkg::STAT_W-1:0]   rsp_status,
   output logic [lpbr_pkg::BYTE_W-1:0]   rsp_data_out,
   output logic [lpbr_pkg::LEN_W-1:0]    rsp_fetch_size,
   output logic                          rsp_last_byte,
   output logic                          rsp_ring_empty
);

   localparam int AW = $clog2(RING_BYTES);
   localparam int CW = $clog2(LEN_BYTES + 1);
   localparam int QW = $clog2(lpbr_pkg::CMDQ_DEPTH + 1);

   // command queue
   lpbr_pkg::lpbr_cmd_type q_ff [lpbr_pkg::CMDQ_DEPTH];
   logic          q_wp_ff, q_rp_ff;
   logic [QW-1:0] q_cnt_ff;
   logic          q_push, q_pop;

   // execute stage
   lpbr_pkg::lpbr_cmd_type cur_ff;
   logic          busy_ff;
   logic [CW-1:0] cnt_ff;
   logic [CW-1:0] target;
   logic          slot_free, done, mem_we, mem_go;
   logic [AW-1:0] mem_addr;
   logic [lpbr_pkg::BYTE_W-1:0] mem_wdata, rdata_ff;
   logic [lpbr_pkg::BYTE_W-1:0] ring_mem [RING_BYTES];

   // result register
   lpbr_pkg::lpbr_cmd_type res_ff;
   logic [lpbr_pkg::BYTE_W-1:0] res_data_ff;
   logic rsp_valid_ff;

   assign cmd_ready = (q_cnt_ff < QW'(lpbr_pkg::CMDQ_DEPTH));
   assign q_push    = cmd_valid && cmd_ready;
   assign q_pop     = !busy_ff && (q_cnt_ff != '0);

   // memory steps per command kind
   always_comb begin
      case (cur_ff.kind)
         lpbr_pkg::CMD_HDR: target = CW'(LEN_BYTES);
         lpbr_pkg::CMD_WR:  target = CW'(1);
         lpbr_pkg::CMD_RD:  target = CW'(1);
         default:           target = '0;
      endcase
   end

   assign slot_free = !rsp_valid_ff || rsp_pop;
   assign mem_go    = busy_ff && (cnt_ff < target);
   assign done      = busy_ff && (cnt_ff == target) && slot_free;
   assign mem_we    = mem_go && (cur_ff.kind != lpbr_pkg::CMD_RD);
   assign mem_addr  = cur_ff.addr[AW-1:0] + AW'(cnt_ff);
   assign mem_wdata = (cur_ff.kind == lpbr_pkg::CMD_HDR) ?
                      lpbr_pkg::BYTE_W'(cur_ff.wdata >> {cnt_ff, 3'b000}) :
                      cur_ff.wdata[lpbr_pkg::BYTE_W-1:0];

   // queue storage
   always_ff @(posedge clock) begin
      if (q_push) begin
         q_ff[q_wp_ff] <= cmd;
      end
   end

   // queue pointers and execute control
   always_ff @(posedge clock) begin
      if (reset) begin
         q_wp_ff      <= 1'b0;
         q_rp_ff      <= 1'b0;
         q_cnt_ff     <= '0;
         busy_ff      <= 1'b0;
         cnt_ff       <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         if (q_push) begin
            q_wp_ff <= !q_wp_ff;
         end
         if (q_pop) begin
            q_rp_ff <= !q_rp_ff;
         end
         q_cnt_ff <= q_cnt_ff + QW'(q_push) - QW'(q_pop);
         if (q_pop) begin
            busy_ff <= 1'b1;
            cnt_ff  <= '0;
         end else if (done) begin
            busy_ff <= 1'b0;
         end else if (mem_go) begin
            cnt_ff <= cnt_ff + 1'b1;
         end
         if (done) begin
            rsp_valid_ff <= 1'b1;
         end else if (rsp_pop) begin
            rsp_valid_ff <= 1'b0;
         end
      end
   end

   // payload registers
   always_ff @(posedge clock) begin
      if (q_pop) begin
         cur_ff <= q_ff[q_rp_ff];
      end
      if (done) begin
         res_ff      <= cur_ff;
         res_data_ff <= (cur_ff.kind == lpbr_pkg::CMD_RD) ? rdata_ff : '0;
      end
   end

   // ring memory, single port; every byte read was written earlier.
   // Read data is held until the result slot frees up.
   always_ff @(posedge clock) begin
      if (mem_we) begin
         ring_mem[mem_addr] <= mem_wdata;
      end
      if (mem_go && !mem_we) begin
         rdata_ff <= ring_mem[mem_addr];
      end
   end

   assign rsp_empty      = !rsp_valid_ff;
   assign rsp_status     = res_ff.status;
   assign rsp_data_out   = res_data_ff;
   assign rsp_fetch_size = res_ff.fetch_size;
   assign rsp_last_byte  = res_ff.last;
   assign rsp_ring_empty = res_ff.empty;

`ifndef SYNTHESIS
   a_q_bound: assert property (@(posedge clock) disable iff (reset)
      q_cnt_ff <= QW'(lpbr_pkg::CMDQ_DEPTH))
      else $error("command queue overfilled");
   a_step: assert property (@(posedge clock) disable iff (reset)
      mem_go && !q_pop |=> cnt_ff == $past(cnt_ff) + 1'b1)
      else $error("memory step counter did not advance");
   a_done_rsp: assert property (@(posedge clock) disable iff (reset)
      done |=> rsp_valid_ff && !busy_ff)
      else $error("completed command left no result");
`endif

endmodule

>>> hdl/length_prefixed_byte_ring.sv
// ----------------------------------------------------------------------------
// length_prefixed_byte_ring
// Byte ring holding records with a little-endian length header.
// ----------------------------------------------------------------------------
// Each item gives one result. The front classifies an item combinationally
// and queues a command; the back runs it on a single-port ring memory. A
// header insert makes one memory write per header byte, a payload byte one,
// a read one memory read, other items none; all pass through the command
// queue. RING_BYTES must be a power of two. No clearing pass follows reset:
// bytes are always written before they are read.
module length_prefixed_byte_ring #(
   parameter int RING_BYTES = lpbr_pkg::RING_BYTES_DEF,
   parameter int LEN_BYTES  = lpbr_pkg::LEN_BYTES_DEF
) (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          req_push,
   output logic                          req_full,
   input  logic [lpbr_pkg::OP_W-1:0]     req_opcode,
   input  logic [lpbr_pkg::LEN_W-1:0]    req_request_len,
   input  logic [lpbr_pkg::BYTE_W-1:0]   req_data_byte,
   output logic                          rsp_empty,
   input  logic                          rsp_pop,
   output logic [lpbr_pkg::STAT_W-1:0]   rsp_status,
   output logic [lpbr_pkg::BYTE_W-1:0]   rsp_data_out,
   output logic [lpbr_pkg::LEN_W-1:0]    rsp_fetch_size,
   output logic                          rsp_last_byte,
   output logic                          rsp_ring_empty,
   input  logic                          csr_valid,
   output logic                          csr_ready,
   input  logic [lpbr_pkg::LIMIT_W-1:0]  csr_data
);

   logic                   cmd_valid, cmd_ready;
   lpbr_pkg::lpbr_cmd_type cmd;

   lpbr_front #(.RING_BYTES(RING_BYTES), .LEN_BYTES(LEN_BYTES)) u_front (
      .clock           (clock),
      .reset           (reset),
      .req_push        (req_push),
      .req_full        (req_full),
      .req_opcode      (req_opcode),
      .req_request_len (req_request_len),
      .req_data_byte   (req_data_byte),
      .csr_valid       (csr_valid),
      .csr_ready       (csr_ready),
      .csr_data        (csr_data),
      .cmd_valid       (cmd_valid),
      .cmd             (cmd),
      .cmd_ready       (cmd_ready)
   );

   lpbr_back #(.RING_BYTES(RING_BYTES), .LEN_BYTES(LEN_BYTES)) u_back (
      .clock          (clock),
      .reset          (reset),
      .cmd_valid      (cmd_valid),
      .cmd            (cmd),
      .cmd_ready      (cmd_ready),
      .rsp_empty      (rsp_empty),
      .rsp_pop        (rsp_pop),
      .rsp_status     (rsp_status),
      .rsp_data_out   (rsp_data_out),
      .rsp_fetch_size (rsp_fetch_size),
      .rsp_last_byte  (rsp_last_byte),
      .rsp_ring_empty (rsp_ring_empty)
   );

endmodule

>>> tb/ring_record_checker.sv
// ----------------------------------------------------------------------------
// ring_record_checker
// Watches the request, response and CSR channels of the byte ring. It keeps
// its own copy of the ring state, works out the response for every accepted
// request, and compares each popped response field by field.
// ----------------------------------------------------------------------------
module ring_record_checker (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          req_push,
   input  logic                          req_full,
   input  logic [lpbr_pkg::OP_W-1:0]     req_opcode,
   input  logic [lpbr_pkg::LEN_W-1:0]    req_request_len,
   input  logic [lpbr_pkg::BYTE_W-1:0]   req_data_byte,
   input  logic                          rsp_empty,
   input  logic                          rsp_pop,
   input  logic [lpbr_pkg::STAT_W-1:0]   rsp_status,
   input  logic [lpbr_pkg::BYTE_W-1:0]   rsp_data_out,
   input  logic [lpbr_pkg::LEN_W-1:0]    rsp_fetch_size,
   input  logic                          rsp_last_byte,
   input  logic                          rsp_ring_empty,
   input  logic                          csr_valid,
   input  logic                          csr_ready,
   input  logic [lpbr_pkg::LIMIT_W-1:0]  csr_data,
   output int                            fail_count,
   output int                            pending
);

   localparam int RING = lpbr_pkg::RING_BYTES_DEF;
   localparam int HDR  = lpbr_pkg::LEN_BYTES_DEF;

   typedef struct packed {
      logic [lpbr_pkg::STAT_W-1:0] status;
      logic [lpbr_pkg::BYTE_W-1:0] data_out;
      logic [lpbr_pkg::LEN_W-1:0]  fetch_size;
      logic                        last_byte;
      logic                        ring_empty;
   } ring_rsp_type;

   // Mirror of the ring state
   logic [lpbr_pkg::BYTE_W-1:0]  ring_mem [RING];
   logic [lpbr_pkg::LEN_W-1:0]   head, tail, wr_ptr, bytes_left, fetch_stop;
   logic                         record_open, fetch_active;
   logic [lpbr_pkg::LIMIT_W-1:0] occ_limit;
   ring_rsp_type                 rsp_queue [$];

   // Work out the response of one request and update the mirror
   function automatic ring_rsp_type ring_step(logic [lpbr_pkg::OP_W-1:0] op,
                                              logic [lpbr_pkg::LEN_W-1:0] len,
                                              logic [lpbr_pkg::BYTE_W-1:0] dbyte);
      ring_rsp_type r;
      int occ, total;
      r = '0;
      occ = int'(lpbr_pkg::LEN_W'(tail - head));
      total = HDR + int'(len);
      case (op)
         lpbr_pkg::OP_INS_HDR: begin
            if (record_open) r.status = lpbr_pkg::ST_SEQ;
            else if (occ >= int'(occ_limit) || total >= RING - occ)
               r.status = lpbr_pkg::ST_REJECT;
            else begin
               wr_ptr = tail;
               for (int i = 0; i < HDR; i++) begin
                  ring_mem[wr_ptr] = lpbr_pkg::BYTE_W'(total >> (8 * i));
                  wr_ptr = wr_ptr + 1'b1;
               end
               bytes_left = len;
               if (len == 0) tail = wr_ptr;
               else record_open = 1'b1;
            end
         end
         lpbr_pkg::OP_INS_BYTE: begin
            if (!record_open) r.status = lpbr_pkg::ST_SEQ;
            else begin
               ring_mem[wr_ptr] = dbyte;
               wr_ptr = wr_ptr + 1'b1;
               bytes_left = bytes_left - 1'b1;
               if (bytes_left == 0) begin
                  tail = wr_ptr;
                  record_open = 1'b0;
               end
            end
         end
         lpbr_pkg::OP_FETCH: begin
            if (fetch_active) r.status = lpbr_pkg::ST_SEQ;
            else if (head == tail) r.status = lpbr_pkg::ST_EMPTY;
            else begin
               fetch_stop = tail;
               fetch_active = 1'b1;
               r.fetch_size = tail - head;
            end
         end
         default: begin
            if (!fetch_active) r.status = lpbr_pkg::ST_SEQ;
            else begin
               r.data_out = ring_mem[head];
               ring_mem[head] = '0;
               head = head + 1'b1;
               if (head == fetch_stop) begin
                  r.last_byte = 1'b1;
                  fetch_active = 1'b0;
               end
            end
         end
      endcase
      r.ring_empty = (head == tail);
      return r;
   endfunction

   task automatic check_field(string name, int exp_val, int act_val);
      if (exp_val != act_val) begin
         $display("%0t: %s mismatch, expected %0h actual %0h", $time, name, exp_val,
                  act_val);
         fail_count++;
      end
   endtask

   // Monitor all three channels; mirror cleared while in reset
   always @(posedge clock) begin
      ring_rsp_type want;
      if (reset) begin
         foreach (ring_mem[i]) ring_mem[i] = '0;
         head = '0; tail = '0; wr_ptr = '0; bytes_left = '0; fetch_stop = '0;
         record_open = 1'b0; fetch_active = 1'b0;
         occ_limit = 13'd4096;
         fail_count = 0;
         rsp_queue.delete();
      end else begin
         if (csr_valid && csr_ready) occ_limit = csr_data;
         if (req_push && !req_full)
            rsp_queue.push_back(ring_step(req_opcode, req_request_len, req_data_byte));
         if (rsp_pop && !rsp_empty) begin
            if (rsp_queue.size() == 0) begin
               $display("%0t: response with nothing expected, actual status %0h", $time,
                        rsp_status);
               fail_count++;
            end else begin
               want = rsp_queue.pop_front();
               check_field("status", want.status, rsp_status);
               check_field("data_out", want.data_out, rsp_data_out);
               check_field("fetch_size", want.fetch_size, rsp_fetch_size);
               check_field("last_byte", want.last_byte, rsp_last_byte);
               check_field("ring_empty", want.ring_empty, rsp_ring_empty);
            end
         end
      end
      pending = rsp_queue.size();
   end

endmodule

>>> tb/tb_top.sv
// ----------------------------------------------------------------------------
// tb_top
// Stimulus and verdict for the length-prefixed byte ring. Directed requests
// cover the sequencing corners, then random record inserts, drains and noise
// run under three sender/receiver idling mixes and several occupancy limits.
// ----------------------------------------------------------------------------
module tb_top;

   localparam int WATCHDOG_MAX = 4000;
   localparam int DRAIN_CYCLES = 16;
   localparam int PHASE_ITEMS  = 250;

   logic                          clock, reset;
   logic                          req_push, req_full;
   logic [lpbr_pkg::OP_W-1:0]     req_opcode;
   logic [lpbr_pkg::LEN_W-1:0]    req_request_len;
   logic [lpbr_pkg::BYTE_W-1:0]   req_data_byte;
   logic                          rsp_empty, rsp_pop;
   logic [lpbr_pkg::STAT_W-1:0]   rsp_status;
   logic [lpbr_pkg::BYTE_W-1:0]   rsp_data_out;
   logic [lpbr_pkg::LEN_W-1:0]    rsp_fetch_size;
   logic                          rsp_last_byte, rsp_ring_empty;
   logic                          csr_valid, csr_ready;
   logic [lpbr_pkg::LIMIT_W-1:0]  csr_data;
   int                            fail_count, pending;
   int                            send_idle_pct, recv_idle_pct;
   int                            items_sent, quiet_cycles;

   length_prefixed_byte_ring uut (.*);

   ring_record_checker u_checker (.*);

   // Clock
   always begin
      clock = 1'b0; #10;
      clock = 1'b1; #10;
   end

   // Receiver pops at random
   always @(posedge clock) begin
      if (reset) rsp_pop <= 1'b0;
      else rsp_pop <= ($urandom_range(0, 99) >= recv_idle_pct);
   end

   // Watchdog: cycles with no transfer on any channel
   always @(posedge clock) begin
      if (reset || (req_push && !req_full) || (rsp_pop && !rsp_empty) ||
          (csr_valid && csr_ready)) begin
         quiet_cycles <= 0;
      end else if (quiet_cycles >= WATCHDOG_MAX) begin
         $display("tb: failure");
         $finish;
      end else begin
         quiet_cycles <= quiet_cycles + 1;
      end
   end

   // One request transfer, with random idle cycles ahead of it
   task automatic send_req(logic [lpbr_pkg::OP_W-1:0] op, logic [lpbr_pkg::LEN_W-1:0] len,
                           logic [lpbr_pkg::BYTE_W-1:0] dbyte);
      logic was_full;
      while ($urandom_range(0, 99) < send_idle_pct) begin
         req_push <= 1'b0;
         @(posedge clock);
      end
      req_push        <= 1'b1;
      req_opcode      <= op;
      req_request_len <= len;
      req_data_byte   <= dbyte;
      do begin
         @(negedge clock);
         was_full = req_full;
         @(posedge clock);
      end while (was_full);
      items_sent++;
   endtask

   // Hold off until every response is back and the back end has settled
   task automatic wait_idle();
      req_push <= 1'b0;
      do @(negedge clock); while (pending != 0);
      repeat (DRAIN_CYCLES) @(posedge clock);
   endtask

   task automatic write_limit(logic [lpbr_pkg::LIMIT_W-1:0] value);
      logic was_ready;
      csr_valid <= 1'b1;
      csr_data  <= value;
      do begin
         @(negedge clock);
         was_ready = csr_ready;
         @(posedge clock);
      end while (!was_ready);
      csr_valid <= 1'b0;
   endtask

   // Header plus payload, sometimes with a stray request in the middle
   task automatic send_record();
      int len;
      len = ($urandom_range(0, 19) == 0) ? $urandom_range(25, 300) : $urandom_range(0, 24);
      send_req(lpbr_pkg::OP_INS_HDR, lpbr_pkg::LEN_W'(len), lpbr_pkg::BYTE_W'($urandom));
      for (int i = 0; i < len; i++) begin
         if ($urandom_range(0, 99) < 3)
            send_req(lpbr_pkg::OP_W'($urandom), lpbr_pkg::LEN_W'($urandom),
                     lpbr_pkg::BYTE_W'($urandom));
         send_req(lpbr_pkg::OP_INS_BYTE, lpbr_pkg::LEN_W'($urandom),
                  lpbr_pkg::BYTE_W'($urandom));
      end
   endtask

   task automatic random_phase(int count);
      int pick, reads;
      items_sent = 0;
      while (items_sent < count) begin
         pick = $urandom_range(0, 99);
         if (pick < 45) begin
            send_record();
         end else if (pick < 80) begin
            reads = $urandom_range(1, 80);
            send_req(lpbr_pkg::OP_FETCH, lpbr_pkg::LEN_W'($urandom),
                     lpbr_pkg::BYTE_W'($urandom));
            repeat (reads) send_req(lpbr_pkg::OP_READ, lpbr_pkg::LEN_W'($urandom),
                                    lpbr_pkg::BYTE_W'($urandom));
         end else if (pick < 88) begin
            // header too long to ever fit
            send_req(lpbr_pkg::OP_INS_HDR, lpbr_pkg::LEN_W'($urandom_range(4092, 4095)),
                     lpbr_pkg::BYTE_W'($urandom));
         end else begin
            send_req(lpbr_pkg::OP_W'($urandom), lpbr_pkg::LEN_W'($urandom),
                     lpbr_pkg::BYTE_W'($urandom));
         end
      end
   endtask

   initial begin
      reset = 1'b1;
      req_push = 1'b0;
      req_opcode = lpbr_pkg::OP_INS_HDR;
      req_request_len = '0;
      req_data_byte = '0;
      csr_valid = 1'b0;
      csr_data = '0;
      send_idle_pct = 0;
      recv_idle_pct = 0;
      repeat (12) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // Directed: sequencing corners and field extremes
      send_req(lpbr_pkg::OP_FETCH, '0, '0);
      send_req(lpbr_pkg::OP_READ, '0, '0);
      send_req(lpbr_pkg::OP_INS_BYTE, '0, 8'hFF);
      send_req(lpbr_pkg::OP_INS_HDR, 12'hFFF, '0);
      send_req(lpbr_pkg::OP_INS_HDR, '0, '0);
      send_req(lpbr_pkg::OP_INS_HDR, 12'd2, '0);
      send_req(lpbr_pkg::OP_INS_HDR, 12'd5, '0);
      send_req(lpbr_pkg::OP_INS_BYTE, '0, 8'h00);
      send_req(lpbr_pkg::OP_INS_BYTE, 12'hFFF, 8'hFF);
      send_req(lpbr_pkg::OP_FETCH, '0, '0);
      send_req(lpbr_pkg::OP_FETCH, '0, '0);
      send_req(lpbr_pkg::OP_INS_HDR, 12'd1, '0);
      send_req(lpbr_pkg::OP_INS_BYTE, '0, 8'hA5);
      repeat (11) send_req(lpbr_pkg::OP_READ, '0, '0);
      wait_idle();
      write_limit('0);
      send_req(lpbr_pkg::OP_INS_HDR, 12'd1, '0);
      wait_idle();
      write_limit(13'h1FFF);

      // Random phases under different idling and limits
      send_idle_pct = 33; recv_idle_pct = 81;
      random_phase(PHASE_ITEMS);
      wait_idle();
      write_limit(13'd1);
      send_idle_pct = 81; recv_idle_pct = 33;
      random_phase(PHASE_ITEMS);
      wait_idle();
      write_limit(lpbr_pkg::LIMIT_W'($urandom_range(16, 600)));
      send_idle_pct = 0; recv_idle_pct = 0;
      random_phase(PHASE_ITEMS);
      wait_idle();
      write_limit(13'd4096);

      if (fail_count == 0) $display("tb: success");
      else $display("tb: failure");
      $finish;
   end

endmodule
